// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define KTS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kts check failed");

// Check a property on every clock edge, reset included
`define KTS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("kts check failed during reset");

`endif

// ===== design/kts_pkg.sv =====
// Shared types and constants of the tree broadcast send scheduler
`default_nettype none
package kts_pkg;

    localparam int NODE_W = 10;
    localparam int K_W    = 5;
    localparam int N_W    = 11;
    localparam int P_W    = 11;
    localparam int T_W    = P_W + K_W;
    localparam int KIND_W = 2;
    localparam int CFG_AW = 1;
    localparam int CFG_DW = 11;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    localparam logic [KIND_W-1:0] KIND_TREE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RING   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_FANOUT     = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_NODE_COUNT = 1'd1;

    localparam logic [K_W-1:0] FANOUT_RESET     = 5'd2;
    localparam logic [N_W-1:0] NODE_COUNT_RESET = 11'd1024;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [K_W-1:0]    k;
        logic [N_W-1:0]    n;
        logic [P_W-1:0]    p;
    } job_t;

endpackage
`default_nettype wire

// ===== design/kts_front.sv =====
// Front end: range and done checks, integer level search, job push
`default_nettype none
module kts_front #(
    parameter int NODES_MAX = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [kts_pkg::NODE_W-1:0] node,
    input  wire logic [kts_pkg::K_W-1:0]    k_eff,
    input  wire logic [kts_pkg::N_W-1:0]    n_eff,
    input  wire logic                       q_full,
    output logic                            push,
    output kts_pkg::job_t                   push_job
);

    localparam int AW = (NODES_MAX > 1) ? $clog2(NODES_MAX) : 1;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LOOK, S_LOG, S_PUSH} state_t;

    state_t                      state_reg;
    logic [AW-1:0]               clr_addr_reg;
    logic [kts_pkg::NODE_W-1:0]  node_reg;
    logic [kts_pkg::K_W-1:0]     k_reg;
    logic [kts_pkg::N_W-1:0]     n_reg;
    logic [kts_pkg::P_W-1:0]     p_reg;
    logic                        rd_done_reg;
    logic                        done_mem [NODES_MAX];

    logic                        accept;
    logic                        in_range;
    logic [kts_pkg::T_W-1:0]     prod;
    logic [kts_pkg::T_W-1:0]     node_plus1;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic                        mem_wdata;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign in_range   = ({1'b0, node} < n_eff);
    assign prod       = {{kts_pkg::K_W{1'b0}}, p_reg} * {{kts_pkg::P_W{1'b0}}, k_reg};
    assign node_plus1 = {{(kts_pkg::T_W - kts_pkg::NODE_W){1'b0}}, node_reg}
                        + kts_pkg::T_W'(1);

    assign push     = (state_reg == S_PUSH) && !q_full;
    assign push_job = '{node: node_reg, k: k_reg, n: n_reg, p: p_reg};

    assign mem_we    = (state_reg == S_CLEAR) || push;
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : AW'(node_reg);
    assign mem_wdata = (state_reg != S_CLEAR);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            done_mem[mem_waddr] <= mem_wdata;
        end
        rd_done_reg <= done_mem[AW'(node)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            node_reg     <= '0;
            k_reg        <= '0;
            n_reg        <= '0;
            p_reg        <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(NODES_MAX - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept && in_range)
                    begin
                        node_reg  <= node;
                        k_reg     <= k_eff;
                        n_reg     <= n_eff;
                        p_reg     <= kts_pkg::P_W'(1);
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    // drop nodes that already ran
                    state_reg <= rd_done_reg ? S_IDLE : S_LOG;
                end
                S_LOG:
                begin
                    if (prod <= node_plus1)
                    begin
                        p_reg <= prod[kts_pkg::P_W-1:0];
                    end
                    else
                    begin
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/kts_queue.sv =====
// Short job queue between front end and send sequencer
`default_nettype none
module kts_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire kts_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output kts_pkg::job_t      head
);

    kts_pkg::job_t             q_mem [kts_pkg::Q_DEPTH];
    logic [kts_pkg::Q_AW-1:0]  wr_ptr_reg;
    logic [kts_pkg::Q_AW-1:0]  rd_ptr_reg;
    logic [kts_pkg::Q_AW:0]    count_reg;

    assign full  = (count_reg == (kts_pkg::Q_AW + 1)'(kts_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + kts_pkg::Q_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + kts_pkg::Q_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (kts_pkg::Q_AW + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (kts_pkg::Q_AW + 1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/kts_back.sv =====
// Send sequencer: tree sends, ring corrections and finish marker
`default_nettype none
module kts_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_empty,
    input  wire kts_pkg::job_t               head,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [kts_pkg::KIND_W-1:0]       kind,
    output logic [kts_pkg::NODE_W-1:0]       sender_node,
    output logic [kts_pkg::NODE_W-1:0]       target_node,
    output logic                             last
);

    typedef enum logic [1:0] {B_IDLE, B_TREE, B_RING, B_FIN} state_t;

    state_t                       state_reg;
    logic [kts_pkg::NODE_W-1:0]   node_reg;
    logic [kts_pkg::K_W-1:0]      k_reg;
    logic [kts_pkg::N_W-1:0]      n_reg;
    logic [kts_pkg::P_W-1:0]      p_reg;
    logic [kts_pkg::K_W-1:0]      i_reg;
    logic [kts_pkg::T_W-1:0]      t_reg;
    logic [kts_pkg::N_W-1:0]      r_reg;
    logic                         out_valid_reg;
    logic [kts_pkg::KIND_W-1:0]   kind_reg;
    logic [kts_pkg::NODE_W-1:0]   sender_reg;
    logic [kts_pkg::NODE_W-1:0]   target_reg;
    logic                         last_reg;

    logic                         out_free;
    logic [kts_pkg::N_W-1:0]      r_next;
    logic                         tree_hit;
    logic                         emit;

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == B_IDLE) && !q_empty;
    assign r_next   = (r_reg == '0) ? (n_reg - kts_pkg::N_W'(1))
                                    : (r_reg - kts_pkg::N_W'(1));
    assign tree_hit = (t_reg < {{(kts_pkg::T_W - kts_pkg::N_W){1'b0}}, n_reg});
    assign emit     = out_free && (((state_reg == B_TREE) && tree_hit)
                                   || (state_reg == B_RING)
                                   || (state_reg == B_FIN));

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign sender_node = sender_reg;
    assign target_node = target_reg;
    assign last        = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            node_reg      <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            p_reg         <= '0;
            i_reg         <= '0;
            t_reg         <= '0;
            r_reg         <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= kts_pkg::KIND_TREE;
            sender_reg    <= '0;
            target_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        node_reg  <= head.node;
                        k_reg     <= head.k;
                        n_reg     <= head.n;
                        p_reg     <= head.p;
                        i_reg     <= kts_pkg::K_W'(1);
                        t_reg     <= {{(kts_pkg::T_W - kts_pkg::NODE_W){1'b0}}, head.node}
                                     + {{kts_pkg::K_W{1'b0}}, head.p};
                        r_reg     <= {{(kts_pkg::N_W - kts_pkg::NODE_W){1'b0}}, head.node};
                        state_reg <= B_TREE;
                    end
                end
                B_TREE:
                begin
                    if (out_free)
                    begin
                        if (tree_hit)
                        begin
                            kind_reg      <= kts_pkg::KIND_TREE;
                            sender_reg    <= node_reg;
                            target_reg    <= t_reg[kts_pkg::NODE_W-1:0];
                            last_reg      <= 1'b0;
                        end
                        // targets only grow, so the first miss ends the tree sends
                        if (!tree_hit || i_reg == k_reg)
                        begin
                            i_reg     <= kts_pkg::K_W'(1);
                            state_reg <= B_RING;
                        end
                        else
                        begin
                            i_reg <= i_reg + kts_pkg::K_W'(1);
                            t_reg <= t_reg + {{kts_pkg::K_W{1'b0}}, p_reg};
                        end
                    end
                end
                B_RING:
                begin
                    if (out_free)
                    begin
                        kind_reg      <= kts_pkg::KIND_RING;
                        sender_reg    <= node_reg;
                        target_reg    <= r_next[kts_pkg::NODE_W-1:0];
                        last_reg      <= 1'b0;
                        r_reg         <= r_next;
                        if (i_reg == k_reg - kts_pkg::K_W'(1))
                        begin
                            state_reg <= B_FIN;
                        end
                        else
                        begin
                            i_reg <= i_reg + kts_pkg::K_W'(1);
                        end
                    end
                end
                B_FIN:
                begin
                    if (out_free)
                    begin
                        kind_reg      <= kts_pkg::KIND_FINISH;
                        sender_reg    <= node_reg;
                        target_reg    <= '0;
                        last_reg      <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/kary_tree_ring_broadcast_sched.sv =====
// Top level of the corrected k-ary tree broadcast send scheduler
// Input channel (in_valid/in_ready, node): one request per node that starts
// receiving; node 0 is the root. Out-of-range or already finished nodes are
// taken and give no results.
// Output channel (out_valid/out_ready): the sends of one node in order, tree
// sends, then fanout-1 ring correction sends, then a finish marker with last.
// Config port: cfg_wr_en/cfg_addr/cfg_wdata writes fanout (0) or node_count
// (1); write only while the block is idle.
// Front: a request passes the done-bit memory read, one multiply per level of
// the log search and the queue push; the sequencer registers the first result
// in its tree state, or in its ring state when no tree target is below
// node_count.
// Throughput: the sequencer gives one result per cycle while the receiver
// is ready, up to 2*fanout per node; the front works on the next request
// meanwhile through a two-entry queue.
// Reset: registers go to fanout 2 and node_count 1024, then a clearing pass
// over all NODES_MAX entries wipes the done-bit memory with in_ready low.
// A stalled receiver holds the output register; the queue fills and then
// in_ready drops.
`default_nettype none
module kary_tree_ring_broadcast_sched #(
    parameter int NODES_MAX  = 1024,
    parameter int FANOUT_MAX = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [kts_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [kts_pkg::CFG_DW-1:0]   cfg_wdata,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [kts_pkg::NODE_W-1:0]   node,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [kts_pkg::KIND_W-1:0]        kind,
    output logic [kts_pkg::NODE_W-1:0]        sender_node,
    output logic [kts_pkg::NODE_W-1:0]        target_node,
    output logic                              last
);

    logic [kts_pkg::K_W-1:0]  fanout_reg;
    logic [kts_pkg::N_W-1:0]  node_count_reg;
    logic [kts_pkg::K_W-1:0]  k_eff;
    logic [kts_pkg::N_W-1:0]  n_eff;

    logic                     q_full;
    logic                     q_empty;
    logic                     push;
    logic                     pop;
    kts_pkg::job_t            push_job;
    kts_pkg::job_t            head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fanout_reg     <= kts_pkg::FANOUT_RESET;
            node_count_reg <= kts_pkg::NODE_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                kts_pkg::CFG_FANOUT:     fanout_reg     <= cfg_wdata[kts_pkg::K_W-1:0];
                kts_pkg::CFG_NODE_COUNT: node_count_reg <= cfg_wdata[kts_pkg::N_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate fanout and node count to their usable ranges
    always_comb
    begin
        if (fanout_reg < kts_pkg::K_W'(2))
        begin
            k_eff = kts_pkg::K_W'(2);
        end
        else if (int'(fanout_reg) > FANOUT_MAX)
        begin
            k_eff = kts_pkg::K_W'(FANOUT_MAX);
        end
        else
        begin
            k_eff = fanout_reg;
        end

        if (node_count_reg == '0)
        begin
            n_eff = kts_pkg::N_W'(1);
        end
        else if (int'(node_count_reg) > NODES_MAX)
        begin
            n_eff = kts_pkg::N_W'(NODES_MAX);
        end
        else
        begin
            n_eff = node_count_reg;
        end
    end

    kts_front #(
        .NODES_MAX (NODES_MAX)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .node     (node),
        .k_eff    (k_eff),
        .n_eff    (n_eff),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    kts_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    kts_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .sender_node (sender_node),
        .target_node (target_node),
        .last        (last)
    );

endmodule
`default_nettype wire

// ===== design/kts_checker.sv =====
// Port-level checker for the broadcast send scheduler, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module kts_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [kts_pkg::KIND_W-1:0]   kind,
    input wire logic [kts_pkg::NODE_W-1:0]   sender_node,
    input wire logic [kts_pkg::NODE_W-1:0]   target_node,
    input wire logic                         last
);

    `KTS_ASSERT(a_last_on_finish, out_valid |-> (last == (kind == kts_pkg::KIND_FINISH)))
    `KTS_ASSERT(a_finish_target_zero, (out_valid && kind == kts_pkg::KIND_FINISH) |-> (target_node == '0))
    `KTS_ASSERT(a_send_not_self_tree, (out_valid && kind == kts_pkg::KIND_TREE) |-> (target_node != sender_node))
    `KTS_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(target_node) && $stable(sender_node)))
    `KTS_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |=> !out_valid)

endmodule

bind kary_tree_ring_broadcast_sched kts_checker u_kts_checker (.*);
`default_nettype wire

// ===== tb/tb_kary_tree_ring_broadcast_sched.sv =====
// Self-checking testbench for the corrected k-ary tree broadcast send scheduler
`timescale 1ns / 100ps
module tb_kary_tree_ring_broadcast_sched;
    import kts_pkg::*;

    localparam int NODES_MAX   = 1024;
    localparam int FANOUT_MAX  = 16;
    localparam int SETTLE      = 24;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 38;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NODE_W-1:0] sender;
        logic [NODE_W-1:0] target;
        logic              last;
    } send_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [NODE_W-1:0] node = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [KIND_W-1:0] kind;
    logic [NODE_W-1:0] sender_node;
    logic [NODE_W-1:0] target_node;
    logic              last;

    logic [K_W-1:0]    fanout_cfg = FANOUT_RESET;
    logic [N_W-1:0]    node_count_cfg = NODE_COUNT_RESET;
    logic              finished_nodes [NODES_MAX];
    logic [NODE_W-1:0] finished_list [$];
    send_t             sends_due [$];

    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int err_count = 0;
    int items_sent = 0;
    int sends_checked = 0;
    int settings_used = 0;
    int stall_cycles = 0;

    kary_tree_ring_broadcast_sched #(
        .NODES_MAX  (NODES_MAX),
        .FANOUT_MAX (FANOUT_MAX)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .node        (node),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .sender_node (sender_node),
        .target_node (target_node),
        .last        (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void push_send(input logic [KIND_W-1:0] k, input logic [NODE_W-1:0] s,
                                      input int t, input logic l);
        send_t e;
        e.kind   = k;
        e.sender = s;
        e.target = t[NODE_W-1:0];
        e.last   = l;
        sends_due.push_back(e);
    endfunction

    function automatic void schedule_sends(input logic [NODE_W-1:0] v);
        int k;
        int n;
        int p;
        int t;
        k = fanout_cfg;
        n = node_count_cfg;
        if (k < 2) k = 2;
        if (k > FANOUT_MAX) k = FANOUT_MAX;
        if (n < 1) n = 1;
        if (n > NODES_MAX) n = NODES_MAX;
        if (v >= n || finished_nodes[v]) return;
        p = 1;
        while (p * k <= v + 1) p = p * k;
        for (int i = 1; i <= k; i++)
        begin
            t = v + i * p;
            if (t < n) push_send(KIND_TREE, v, t, 1'b0);
        end
        for (int i = 1; i < k; i++)
        begin
            t = (v + n - (i % n)) % n;
            push_send(KIND_RING, v, t, 1'b0);
        end
        push_send(KIND_FINISH, v, 0, 1'b1);
        finished_nodes[v] = 1'b1;
        finished_list.push_back(v);
    endfunction

    always @(posedge clk)
    begin
        send_t exp;
        if (out_valid && out_ready)
        begin
            if (sends_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected send kind %0d %0d->%0d last %0b",
                                          kind, sender_node, target_node, last));
            end
            else
            begin
                exp = sends_due.pop_front();
                sends_checked++;
                if (kind !== exp.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", kind, exp.kind));
                if (sender_node !== exp.sender)
                    report_mismatch($sformatf("sender %0d, want %0d", sender_node, exp.sender));
                if (target_node !== exp.target)
                    report_mismatch($sformatf("target %0d, want %0d (sender %0d)",
                                              target_node, exp.target, exp.sender));
                if (last !== exp.last)
                    report_mismatch($sformatf("last %0b, want %0b (sender %0d)",
                                              last, exp.last, exp.sender));
            end
        end
        if (rst_n) out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("watchdog: no handshake for %0d cycles, %0d sends outstanding",
                 STALL_LIMIT, sends_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_node(input logic [NODE_W-1:0] v);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        node     <= v;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        schedule_sends(v);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sends_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (addr == CFG_FANOUT)
            fanout_cfg = data[K_W-1:0];
        else
            node_count_cfg = data[N_W-1:0];
        settings_used++;
    endtask

    task automatic test_reset_config();
        send_node(10'd5);
        send_node(10'd1023);
    endtask

    task automatic test_single_node();
        write_reg(CFG_NODE_COUNT, 11'd0);
        write_reg(CFG_FANOUT, 11'd31);
        send_node(10'd0);
        send_node(10'd1);
        send_node(10'd1023);
        write_reg(CFG_NODE_COUNT, 11'd1);
        send_node(10'd0);
    endtask

    task automatic test_fanout_limits();
        write_reg(CFG_FANOUT, 11'd1);
        write_reg(CFG_NODE_COUNT, 11'd2047);
        send_node(10'd1);
        send_node(10'd2);
        send_node(10'd1);
        write_reg(CFG_FANOUT, 11'd0);
        send_node(10'd6);
        write_reg(CFG_FANOUT, 11'h7E3);
        send_node(10'd7);
        send_node(10'd8);
    endtask

    task automatic test_wide_fanout();
        write_reg(CFG_FANOUT, 11'd16);
        write_reg(CFG_NODE_COUNT, 11'd1024);
        send_node(10'd3);
        send_node(10'd15);
        send_node(10'd255);
        send_node(10'd14);
    endtask

    task automatic test_node_count_bound();
        write_reg(CFG_FANOUT, 11'd2);
        write_reg(CFG_NODE_COUNT, 11'd1000);
        send_node(10'd999);
        send_node(10'd1000);
        send_node(10'd500);
    endtask

    task automatic test_random_phase(input logic [CFG_DW-1:0] k_data,
                                     input logic [CFG_DW-1:0] n_data,
                                     input int idle_pct, input int stall_pct);
        int n;
        int start;
        int r;
        logic [NODE_W-1:0] v;
        logic found;
        write_reg(CFG_FANOUT, k_data);
        write_reg(CFG_NODE_COUNT, n_data);
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        n = node_count_cfg;
        if (n < 1) n = 1;
        if (n > NODES_MAX) n = NODES_MAX;
        for (int j = 0; j < PHASE_ITEMS; j++)
        begin
            r = $urandom_range(99);
            v = NODE_W'($urandom_range(NODES_MAX - 1));
            if (r < 80)
            begin
                found = 1'b0;
                start = $urandom_range(n - 1);
                for (int m = 0; m < n && !found; m++)
                begin
                    if (!finished_nodes[(start + m) % n])
                    begin
                        v = NODE_W'((start + m) % n);
                        found = 1'b1;
                    end
                end
            end
            else if (r < 90 && finished_list.size() != 0)
            begin
                v = finished_list[$urandom_range(finished_list.size() - 1)];
            end
            send_node(v);
        end
        in_idle_pct   = 0;
        out_stall_pct = 0;
    endtask

    initial
    begin
        foreach (finished_nodes[i]) finished_nodes[i] = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_single_node();
        test_fanout_limits();
        test_wide_fanout();
        test_node_count_bound();

        test_random_phase(11'd2, 11'd1024, 0, 0);
        test_random_phase(11'd16, 11'd1024, 82, 0);
        test_random_phase(11'd3, 11'd700, 0, 82);
        test_random_phase(11'd5, 11'd2047, 9, 9);
        test_random_phase(11'd31, 11'd1024, 0, 0);
        test_random_phase(CFG_DW'($urandom_range(2, 16)), CFG_DW'($urandom_range(512, 1024)),
                          82, 0);
        test_random_phase(CFG_DW'($urandom_range(2, 16)), CFG_DW'($urandom_range(512, 1024)),
                          0, 82);
        test_random_phase(CFG_DW'($urandom_range(2, 16)), CFG_DW'($urandom_range(512, 1024)),
                          9, 9);

        wait_idle();
        if (sends_due.size() != 0)
            report_mismatch($sformatf("%0d sends never arrived", sends_due.size()));
        $display("Covered %0d node requests over %0d register writes, %0d sends checked.",
                 items_sent, settings_used, sends_checked);
        $display("Fanout 0..31 with saturation, node_count 0..2047, four handshake load modes.");
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
